/* rtl/core/sos_pkg.sv */
// Shared widths and defaults for the sorted order statistics core.
// No dependencies; imported by sos_div, the core and the testbench.
`default_nettype none
package sos_pkg;

  localparam int SAMPLE_W  = 24;  // sample and most result fields
  localparam int CHANGE_W  = 25;  // signed difference of two samples
  localparam int SUM_W     = 31;  // running sum of one set
  localparam int COUNT_DEF = 16;  // samples per set

endpackage
`default_nettype wire

/* rtl/core/sos_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none
module sos_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/core/sos_div.sv */
// Division of a set sum by the constant set size: a reciprocal multiply, then a scale.
// Depends on sos_pkg for the sample and sum widths.
`default_nettype none
module sos_div #(
  parameter int COUNT = sos_pkg::COUNT_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [sos_pkg::SUM_W-1:0] dividend,
  output logic                           busy,
  output logic      [sos_pkg::SUM_W-1:0] quotient
);
  import sos_pkg::*;

  localparam int AW = $clog2(COUNT);
  // a sum of COUNT samples stays below 2^NW
  localparam int NW = SAMPLE_W + AW;
  localparam int SH = NW + AW;
  localparam int MW = NW + 1;
  localparam int PW = NW + MW;
  // ceil(2^SH / COUNT) is exact for every dividend below 2^NW
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) + 64'(COUNT) - 64'd1) / 64'(COUNT));

  logic [PW-1:0] product;

  // multiply on start, scale into the quotient on the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else begin
      busy <= start;
    end
    if (start) begin
      product <= PW'(dividend[NW-1:0]) * PW'(RECIP);
    end
    if (busy) begin
      quotient <= SUM_W'(product[PW-1:SH]);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sorted_order_statistics_core.sv */
// Order statistics (highest, lowest, mean, median, change) of a set of samples.
// Depends on sos_pkg, sos_ram and sos_div.
//
// Usage:
//   Samples enter on sample/in_valid/in_ready, COUNT of them to a set. Each is
//   insertion-sorted into a RAM: the sequencer reads one stored entry a cycle
//   and moves it up one place while it is larger than the new sample; in_ready
//   is low while a sample is being inserted.
//   After the COUNT-th sample one result appears on out_valid/out_ready with
//   highest, lowest, mean, middle and change. The mean comes from a registered
//   reciprocal multiply by 1/COUNT; after the last insertion four RAM reads, the
//   median and the mean are done before out_valid rises.
//   While the result waits for out_ready no new sample is taken; once it is
//   taken the set counters are already clear and the next set starts.
//   Reset (rst, synchronous) empties the set and drops any pending result.
//   The RAM contents are not cleared; entries are only read after a write.
`default_nettype none
module sorted_order_statistics_core #(
  parameter int COUNT = sos_pkg::COUNT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic        [sos_pkg::SAMPLE_W-1:0] sample,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic             [sos_pkg::SAMPLE_W-1:0] highest,
  output logic             [sos_pkg::SAMPLE_W-1:0] lowest,
  output logic             [sos_pkg::SAMPLE_W-1:0] mean,
  output logic             [sos_pkg::SAMPLE_W-1:0] middle,
  output logic signed      [sos_pkg::CHANGE_W-1:0] change
);
  import sos_pkg::*;

  localparam int  AW   = $clog2(COUNT);
  localparam int  HALF = COUNT / 2;
  localparam bit  EVEN = (COUNT % 2) == 0;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_CMP, S_RD_HI, S_RD_LO, S_RD_M0, S_RD_M1, S_MED, S_DIV, S_OUT
  } state_t;

  state_t              state;
  logic [AW-1:0]       filled;
  logic [AW-1:0]       pos;
  logic                last;
  logic [SAMPLE_W-1:0] v;
  logic [SAMPLE_W-1:0] first;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] m0;
  logic [SAMPLE_W:0]   m_sum;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  logic                ins_end;
  logic                shift;
  logic                div_start;
  logic                div_busy;
  logic [SUM_W-1:0]    div_q;
  logic                in_acc;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign div_start = ins_end && last;
  assign m_sum     = {1'b0, m0} + {1'b0, ram_rdata};

  sos_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sos_div #(
    .COUNT(COUNT)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum),
    .busy    (div_busy),
    .quotient(div_q)
  );

  // RAM port steering for the insertion and the final reads
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = v;
    ram_raddr = pos - 1'b1;
    ins_end   = 1'b0;
    shift     = 1'b0;
    unique case (state)
      S_INS: begin
        if (pos == '0) begin
          ram_we  = 1'b1;
          ins_end = 1'b1;
        end
      end
      S_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata > v) begin
          // move the larger entry up and fetch the next one down
          ram_wdata = ram_rdata;
          ram_raddr = pos - AW'(2);
          shift     = 1'b1;
        end else begin
          ins_end = 1'b1;
        end
      end
      S_RD_HI: ram_raddr = AW'(COUNT - 1);
      S_RD_LO: ram_raddr = '0;
      S_RD_M0: ram_raddr = AW'(HALF - 1);
      S_RD_M1: ram_raddr = AW'(HALF);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      filled    <= '0;
      sum       <= '0;
      first     <= '0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            v     <= sample;
            pos   <= filled;
            sum   <= sum + SUM_W'(sample);
            state <= S_INS;
            if (filled == '0) begin
              first <= sample;
            end
            if (filled == AW'(COUNT - 1)) begin
              last   <= 1'b1;
              filled <= '0;
              change <= signed'({1'b0, sample} - {1'b0, first});
              first  <= '0;
            end else begin
              last   <= 1'b0;
              filled <= filled + 1'b1;
            end
          end
        end
        S_INS, S_CMP: begin
          if (shift) begin
            pos <= pos - 1'b1;
            if (pos == AW'(1)) begin
              state <= S_INS;
            end else begin
              state <= S_CMP;
            end
          end else if (ins_end) begin
            if (last) begin
              sum   <= '0;
              state <= S_RD_HI;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            state <= S_CMP;
          end
        end
        S_RD_HI: state <= S_RD_LO;
        S_RD_LO: begin
          highest <= ram_rdata;
          state   <= S_RD_M0;
        end
        S_RD_M0: begin
          lowest <= ram_rdata;
          state  <= S_RD_M1;
        end
        S_RD_M1: begin
          m0    <= ram_rdata;
          state <= S_MED;
        end
        S_MED: begin
          middle <= EVEN ? m_sum[SAMPLE_W:1] : ram_rdata;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            mean      <= div_q[SAMPLE_W-1:0];
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> (filled == '0 && sum == '0))
    else $error("set not cleared after result");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !div_busy)
    else $error("result raised while divider busy");

  a_ram_idle_out: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_INS || state == S_CMP))
    else $error("sort RAM written outside insertion");

endmodule
`default_nettype wire

/* tb/tb_sorted_order_statistics_core.sv */
// Testbench for sorted_order_statistics_core: set-by-set price statistics checked
// against an in-bench insertion-sort model. Depends on sos_pkg and the core RTL.
`default_nettype none
module tb_sorted_order_statistics_core;
  import sos_pkg::*;

  localparam int COUNT = COUNT_DEF;
  localparam int DIR_N = 25;
  localparam int RAND_ITEMS = 825;
  localparam logic [SAMPLE_W-1:0] TOP = {SAMPLE_W{1'b1}};

  typedef struct packed {
    logic [SAMPLE_W-1:0] highest;
    logic [SAMPLE_W-1:0] lowest;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] middle;
    logic signed [CHANGE_W-1:0] change;
  } stats_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    bit typed;
    stats_t result;
  } row_t;

  localparam stats_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [SAMPLE_W-1:0] highest, lowest, mean, middle;
  logic signed [CHANGE_W-1:0] change;

  sorted_order_statistics_core #(.COUNT(COUNT)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .highest(highest), .lowest(lowest), .mean(mean), .middle(middle), .change(change)
  );

  always #1 clk = ~clk;

  // model state
  logic [SAMPLE_W-1:0] sorted_copy [COUNT];
  int unsigned set_fill;
  logic [SUM_W-1:0] set_sum;
  logic [SAMPLE_W-1:0] set_first;

  stats_t pending_stats [$];
  int errors = 0;
  int idle_odds = 0;      // 0: no idling; otherwise larger means rarer bursts
  bit row_typed = 1'b0;   // current request carries a typed-in result
  stats_t row_result = NO_RES;
  row_t dir_table [DIR_N];

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // Insert one sample and, on the last of a set, produce its statistics.
  task automatic absorb_sample(input logic [SAMPLE_W-1:0] v, output bit done,
                               output stats_t res);
    int unsigned pos;
    logic [SAMPLE_W:0] pair;
    logic [SUM_W-1:0] quot;
    done = 1'b0;
    res = NO_RES;
    if (set_fill == 0) set_first = v;
    pos = (set_fill >= COUNT) ? COUNT - 1 : set_fill;
    while (pos > 0 && sorted_copy[pos-1] > v) begin
      sorted_copy[pos] = sorted_copy[pos-1];
      pos--;
    end
    sorted_copy[pos] = v;
    set_fill++;
    set_sum = set_sum + SUM_W'(v);
    if (set_fill >= COUNT) begin
      if (COUNT % 2 == 0) begin
        pair = {1'b0, sorted_copy[COUNT/2-1]} + {1'b0, sorted_copy[COUNT/2]};
        res.middle = pair[SAMPLE_W:1];
      end else begin
        res.middle = sorted_copy[COUNT/2];
      end
      quot = SUM_W'(set_sum / COUNT);
      res.highest = sorted_copy[COUNT-1];
      res.lowest = sorted_copy[0];
      res.mean = quot[SAMPLE_W-1:0];
      res.change = {1'b0, v} - {1'b0, set_first};
      done = 1'b1;
      set_fill = 0;
      set_sum = '0;
      set_first = '0;
    end
  endtask

  always @(posedge clk) begin
    bit done;
    stats_t res;
    if (!rst && in_valid && in_ready) begin
      absorb_sample(sample, done, res);
      if (done) pending_stats.push_back(row_typed ? row_result : res);
    end
  end

  always @(posedge clk) begin
    stats_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        flag_mismatch("result with no completed set behind it");
      end else begin
        want = pending_stats.pop_front();
        if (highest !== want.highest)
          flag_mismatch($sformatf("highest %h, want %h", highest, want.highest));
        if (lowest !== want.lowest)
          flag_mismatch($sformatf("lowest %h, want %h", lowest, want.lowest));
        if (mean !== want.mean)
          flag_mismatch($sformatf("mean %h, want %h", mean, want.mean));
        if (middle !== want.middle)
          flag_mismatch($sformatf("middle %h, want %h", middle, want.middle));
        if (change !== want.change)
          flag_mismatch($sformatf("change %0d, want %0d", change, want.change));
      end
    end
  end

  // Result side: random stall bursts while idling is enabled.
  int stall_left = 0;
  always @(negedge clk) begin
    logic rdy;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else if (idle_odds != 0 && $urandom_range(0, idle_odds * 3) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    out_ready <= rdy;
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit typed,
                             input stats_t res);
    int gap;
    gap = 0;
    if (idle_odds != 0 && $urandom_range(0, idle_odds * 2) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    row_typed = typed;
    row_result = res;
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the next request back until every pending result has been taken.
  task automatic hold_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(negedge clk);
  endtask

  initial begin
    int sent, pos, mode, set_no, step, waited;
    logic [SAMPLE_W-1:0] v, base;

    set_fill = 0;
    set_sum = '0;
    set_first = '0;
    foreach (sorted_copy[i]) sorted_copy[i] = '0;

    // Set one alternates the extremes, first at the top and last at zero.
    // Set two opens at zero and mixes a descending run with equal samples.
    dir_table = '{
      '{TOP, 1'b0, NO_RES}, '{24'd0, 1'b0, NO_RES},
      '{TOP, 1'b0, NO_RES}, '{24'd0, 1'b0, NO_RES},
      '{TOP, 1'b0, NO_RES}, '{24'd0, 1'b0, NO_RES},
      '{TOP, 1'b0, NO_RES}, '{24'd0, 1'b0, NO_RES},
      '{TOP, 1'b0, NO_RES}, '{24'd0, 1'b0, NO_RES},
      '{TOP, 1'b0, NO_RES}, '{24'd0, 1'b0, NO_RES},
      '{TOP, 1'b0, NO_RES}, '{24'd0, 1'b0, NO_RES},
      '{TOP, 1'b0, NO_RES},
      '{24'd0, 1'b1, '{TOP, 24'h000000, 24'h7FFFFF, 24'h7FFFFF, -25'sd16777215}},
      '{24'd0, 1'b0, NO_RES}, '{24'd1000, 1'b0, NO_RES},
      '{24'd999, 1'b0, NO_RES}, '{24'd999, 1'b0, NO_RES},
      '{24'd500, 1'b0, NO_RES}, '{24'd1, 1'b0, NO_RES},
      '{24'hFFFFFE, 1'b0, NO_RES}, '{24'd1, 1'b0, NO_RES},
      '{24'h800000, 1'b0, NO_RES}
    };

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    sent = 0;
    for (int i = 0; i < DIR_N; i++) begin
      if (i == COUNT) hold_for_results();
      send_sample(dir_table[i].value, dir_table[i].typed, dir_table[i].result);
      sent++;
    end

    mode = 0;
    set_no = 0;
    base = '0;
    step = 0;
    while (sent < DIR_N + RAND_ITEMS || sent % COUNT != 0) begin
      pos = sent % COUNT;
      if (pos == 0) begin
        set_no++;
        if (set_no % 9 == 4) hold_for_results();
        mode = $urandom_range(0, 6);
        base = SAMPLE_W'($urandom);
        step = $urandom_range(0, 1 << 19);
        idle_odds = (sent >= DIR_N + RAND_ITEMS - 6 * COUNT) ? 0 : $urandom_range(0, 3);
      end
      case (mode)
        1: v = $urandom_range(0, 1) ? TOP : '0;
        2: v = base + SAMPLE_W'($urandom_range(0, 3));
        3: v = {1'b0, base[SAMPLE_W-2:0]} + SAMPLE_W'(pos * step);
        4: v = TOP - {1'b0, base[SAMPLE_W-2:0]} - SAMPLE_W'(pos * step);
        5: v = (pos == 0) ? '0 : (pos == COUNT - 1) ? TOP : SAMPLE_W'($urandom);
        6: v = (pos == 0) ? TOP : (pos == COUNT - 1) ? '0 : SAMPLE_W'($urandom);
        default: v = SAMPLE_W'($urandom);
      endcase
      send_sample(v, 1'b0, NO_RES);
      sent++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_stats.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_stats.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_stats.size()));
    repeat (COUNT + 40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire
